/* rtl/swi_pkg.sv */
package swi_pkg;

    // fixed widths of the arithmetic
    localparam int SUM_W   = 33;   // wrapping coherent sums
    localparam int LEN_W   = 17;   // window length and sample count
    localparam int ALPHA_W = 16;   // smoothing coefficient, Q0.16
    localparam int PP_W    = 50;   // 33 x 17 partial product
    localparam int ACC_W   = 67;   // exact product sums, doubled
    localparam int QUO_W   = 64;   // kept quotient bits
    localparam int DIVD_W  = 67;   // divider dividend
    localparam int DIVS_W  = 49;   // divider divisor
    localparam int I_W     = 49;   // intensity fields
    localparam int S_W     = 50;   // signed stokes fields
    localparam int R_W     = 16;   // Q1.15 ratios
    localparam int Q_DEPTH = 2;    // window queue depth
    localparam int CFG_IDX_W = 2;

    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_MAX_WINDOW  = 65536;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP  = 2'd2;

    // one closed window handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] shr;
        logic [SUM_W-1:0] shi;
        logic [SUM_W-1:0] svr;
        logic [SUM_W-1:0] svi;
        logic [LEN_W-1:0] n;
    } swi_win_t;

    typedef struct packed {
        logic full;
        logic empty;
    } swi_qstat_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_DRAIN,
        B_DIFF,
        B_DIV,
        B_DIV_W,
        B_SM_MUL,
        B_SM_UPD,
        B_RAT,
        B_RAT_W,
        B_RMUL,
        B_RUPD,
        B_OUT
    } swi_bstate_t;

    typedef enum logic [2:0] {
        DST_PQ,
        DST_NQ,
        DST_PU,
        DST_NU,
        DST_PV,
        DST_NV
    } swi_dst_t;

endpackage

/* rtl/stokes_window_integrator_top.sv */
// window-end math, back end idle: pop the window, 16 partial products, four divisions by N,
// then per ratio either a saturated or zero result or a 67-bit division
// throughput: one sample request per cycle inside a window while the 2-deep queue has room;
// the shared divider sets the window-end cost, and intake stalls once the queue fills
// reset: aresetn is synchronous, active low; clears registers, sums, count and smoothers
module stokes_window_integrator_top import swi_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [LEN_W-1:0]       cfg_wdata,
    // sample requests
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_h_real,
    input  logic [SAMPLE_BITS-1:0] s_h_imag,
    input  logic [SAMPLE_BITS-1:0] s_v_real,
    input  logic [SAMPLE_BITS-1:0] s_v_imag,
    // result requests
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [I_W-1:0]         m_total_intensity,
    output logic signed [S_W-1:0]  m_linear_q,
    output logic signed [S_W-1:0]  m_linear_u,
    output logic signed [S_W-1:0]  m_circular_v,
    output logic [I_W-1:0]         m_smoothed_intensity,
    output logic signed [R_W-1:0]  m_smoothed_q_ratio,
    output logic signed [R_W-1:0]  m_smoothed_u_ratio,
    output logic signed [R_W-1:0]  m_smoothed_v_ratio
);

    // configuration registers
    logic [LEN_W-1:0]   len_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic               swap_reg;

    // front to queue to back
    logic       push, pop;
    swi_win_t   push_win, head_win;
    swi_qstat_t qstat;

    // shared divider
    logic              div_start, div_done;
    logic [DIVD_W-1:0] div_dividend, div_quotient;
    logic [DIVS_W-1:0] div_divisor;

    // back outputs, before the signed view on the ports
    logic [S_W-1:0] q_raw, u_raw, v_raw;
    logic [R_W-1:0] rq_raw, ru_raw, rv_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            alpha_reg <= '0;
            swap_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_LEN:   len_reg   <= cfg_wdata;
                CFG_ALPHA: alpha_reg <= cfg_wdata[ALPHA_W-1:0];
                CFG_SWAP:  swap_reg  <= cfg_wdata[0];
                default: ;   // unused index, write dropped
            endcase
        end
    end

    // front: swap, accumulate, count, close windows
    swi_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .len      (len_reg),
        .swap     (swap_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .h_real   (s_h_real),
        .h_imag   (s_h_imag),
        .v_real   (s_v_real),
        .v_imag   (s_v_imag),
        .qstat    (qstat),
        .push     (push),
        .push_win (push_win)
    );

    // closed windows wait here so intake keeps going during window-end math
    swi_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_win (push_win),
        .pop      (pop),
        .head_win (head_win),
        .stat     (qstat)
    );

    // back: products, divisions, smoothing, result register
    swi_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .alpha              (alpha_reg),
        .qstat              (qstat),
        .head_win           (head_win),
        .pop                (pop),
        .div_start          (div_start),
        .div_dividend       (div_dividend),
        .div_divisor        (div_divisor),
        .div_done           (div_done),
        .div_quotient       (div_quotient),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .total_intensity    (m_total_intensity),
        .linear_q           (q_raw),
        .linear_u           (u_raw),
        .circular_v         (v_raw),
        .smoothed_intensity (m_smoothed_intensity),
        .smoothed_q_ratio   (rq_raw),
        .smoothed_u_ratio   (ru_raw),
        .smoothed_v_ratio   (rv_raw)
    );

    // one bit per cycle divider, shared by N and ratio divisions
    swi_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_linear_q         = q_raw;
    assign m_linear_u         = u_raw;
    assign m_circular_v       = v_raw;
    assign m_smoothed_q_ratio = rq_raw;
    assign m_smoothed_u_ratio = ru_raw;
    assign m_smoothed_v_ratio = rv_raw;

endmodule

/* rtl/swi_div.sv */
module swi_div import swi_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVD_W-1:0] dvd_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W:0]   diff;
    logic              fits;

    // restoring, one quotient bit per cycle
    assign trial = {rem_reg, dvd_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIVD_W-2:0], 1'b0};
            rem_reg <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/swi_queue.sv */
module swi_queue import swi_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  swi_win_t   push_win,
    input  logic       pop,
    output swi_win_t   head_win,
    output swi_qstat_t stat
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    swi_win_t         mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_win;
        end
    end

    assign head_win   = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CNT_W'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !stat.full)
        else $error("window queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty)
        else $error("window queue underflow");
    a_cnt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("window queue count lost a push");
`endif

endmodule

/* rtl/swi_front.sv */
module swi_front import swi_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [LEN_W-1:0]       len,
    input  logic                   swap,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] h_real,
    input  logic [SAMPLE_BITS-1:0] h_imag,
    input  logic [SAMPLE_BITS-1:0] v_real,
    input  logic [SAMPLE_BITS-1:0] v_imag,
    input  swi_qstat_t             qstat,
    output logic                   push,
    output swi_win_t               push_win
);

    localparam int CLAMP = (MAX_WINDOW < (2 ** LEN_W) - 1) ? MAX_WINDOW : (2 ** LEN_W) - 1;
    localparam int EXT_W = SUM_W - SAMPLE_BITS;

    logic [SUM_W-1:0] shr_reg, shi_reg, svr_reg, svi_reg;
    logic [SUM_W-1:0] shr_next, shi_next, svr_next, svi_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] len_eff;
    logic [SUM_W-1:0] xhr, xhi, xvr, xvi;
    logic             enabled, accept, close;

    assign len_eff = (len > LEN_W'(CLAMP)) ? LEN_W'(CLAMP) : len;
    assign enabled = (len != '0);
    // disabled: samples are taken and dropped
    assign s_ready = !enabled || !qstat.full;
    assign accept  = s_valid && s_ready && enabled;

    assign xhr = {{EXT_W{h_real[SAMPLE_BITS-1]}}, h_real};
    assign xhi = {{EXT_W{h_imag[SAMPLE_BITS-1]}}, h_imag};
    assign xvr = {{EXT_W{v_real[SAMPLE_BITS-1]}}, v_real};
    assign xvi = {{EXT_W{v_imag[SAMPLE_BITS-1]}}, v_imag};

    always_comb begin
        shr_next = shr_reg + (swap ? xvr : xhr);
        shi_next = shi_reg + (swap ? xvi : xhi);
        svr_next = svr_reg + (swap ? xhr : xvr);
        svi_next = svi_reg + (swap ? xhi : xvi);
        cnt_next = cnt_reg + 1'b1;
    end

    assign close = accept && (cnt_next >= len_eff);
    assign push  = close;

    always_comb begin
        push_win.shr = shr_next;
        push_win.shi = shi_next;
        push_win.svr = svr_next;
        push_win.svi = svi_next;
        push_win.n   = cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shr_reg <= '0;
            shi_reg <= '0;
            svr_reg <= '0;
            svi_reg <= '0;
            cnt_reg <= '0;
        end else if (close) begin
            shr_reg <= '0;
            shi_reg <= '0;
            svr_reg <= '0;
            svi_reg <= '0;
            cnt_reg <= '0;
        end else if (accept) begin
            shr_reg <= shr_next;
            shi_reg <= shi_next;
            svr_reg <= svr_next;
            svi_reg <= svi_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/swi_back.sv */
module swi_back import swi_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [ALPHA_W-1:0] alpha,
    input  swi_qstat_t         qstat,
    input  swi_win_t           head_win,
    output logic               pop,
    output logic               div_start,
    output logic [DIVD_W-1:0]  div_dividend,
    output logic [DIVS_W-1:0]  div_divisor,
    input  logic               div_done,
    input  logic [DIVD_W-1:0]  div_quotient,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [I_W-1:0]     total_intensity,
    output logic [S_W-1:0]     linear_q,
    output logic [S_W-1:0]     linear_u,
    output logic [S_W-1:0]     circular_v,
    output logic [I_W-1:0]     smoothed_intensity,
    output logic [R_W-1:0]     smoothed_q_ratio,
    output logic [R_W-1:0]     smoothed_u_ratio,
    output logic [R_W-1:0]     smoothed_v_ratio
);

    swi_bstate_t state_reg, state_next;

    logic [SUM_W-1:0] mag_reg [4];
    logic [3:0]       neg_reg;
    logic [LEN_W-1:0] n_reg;
    logic [3:0]       step_reg;
    logic [1:0]       idx_reg;

    logic [PP_W-1:0]  pp_reg;
    logic             pp_hi_reg;
    logic             pp_vld_reg;
    swi_dst_t         pp_dst_reg;
    logic [ACC_W-1:0] acc_reg [6];

    logic [DIVD_W-1:0] dvd_reg [4];
    logic [3:0]        sgn_reg;
    logic [QUO_W-1:0]  quo_reg [4];

    logic [I_W-1:0]   avg_i_reg;
    logic [R_W-1:0]   avg_r_reg [3];
    logic [I_W-1:0]   smp_hi_reg;
    logic [31:0]      smp_lo_reg;
    logic             sm_ge_reg;
    logic [R_W-1:0]   rat_reg;
    logic [32:0]      rprod_reg;
    logic             rneg_reg;

    logic             m_valid_reg;
    logic [I_W-1:0]   o_i_reg, o_si_reg;
    logic [S_W-1:0]   o_q_reg, o_u_reg, o_v_reg;
    logic [R_W-1:0]   o_rq_reg, o_ru_reg, o_rv_reg;

    // product sequencing
    logic [2:0]       pidx;
    logic [SUM_W-1:0] mul_x, mul_y;
    logic [16:0]      mul_yh;
    logic [PP_W-1:0]  prod;
    swi_dst_t         dst;
    logic [ACC_W-1:0] pp_ext;

    // window-end arithmetic
    logic [ACC_W-1:0] sum_i, dq, du, dv;
    logic             lt_q, lt_u, lt_v;
    logic [I_W-1:0]   ival, dsm;
    logic             ge_i;
    logic [QUO_W-1:0] rmag;
    logic             rneg;
    logic [R_W-1:0]   q16, y16;
    logic [16:0]      dd17, dmag;
    logic [16:0]      rstep;
    logic             out_load;

    function automatic logic [SUM_W-1:0] smag(input logic [SUM_W-1:0] s);
        smag = s[SUM_W-1] ? (~s + 1'b1) : s;
    endfunction

    assign pidx = step_reg[3:1];

    always_comb begin
        mul_x = mag_reg[0];
        mul_y = mag_reg[0];
        dst   = DST_PQ;
        unique case (pidx)
            3'd0: begin mul_x = mag_reg[0]; mul_y = mag_reg[0]; dst = DST_PQ; end
            3'd1: begin mul_x = mag_reg[1]; mul_y = mag_reg[1]; dst = DST_PQ; end
            3'd2: begin mul_x = mag_reg[2]; mul_y = mag_reg[2]; dst = DST_NQ; end
            3'd3: begin mul_x = mag_reg[3]; mul_y = mag_reg[3]; dst = DST_NQ; end
            3'd4: begin
                mul_x = mag_reg[0]; mul_y = mag_reg[2];
                dst = (neg_reg[0] ^ neg_reg[2]) ? DST_NU : DST_PU;
            end
            3'd5: begin
                mul_x = mag_reg[1]; mul_y = mag_reg[3];
                dst = (neg_reg[1] ^ neg_reg[3]) ? DST_NU : DST_PU;
            end
            3'd6: begin
                mul_x = mag_reg[1]; mul_y = mag_reg[2];
                dst = (neg_reg[1] ^ neg_reg[2]) ? DST_NV : DST_PV;
            end
            3'd7: begin
                // a*d enters V with negative weight
                mul_x = mag_reg[0]; mul_y = mag_reg[3];
                dst = (neg_reg[0] ^ neg_reg[3]) ? DST_PV : DST_NV;
            end
            default: begin mul_x = mag_reg[0]; mul_y = mag_reg[0]; dst = DST_PQ; end
        endcase
    end

    assign mul_yh = step_reg[0] ? mul_y[SUM_W-1:16] : {1'b0, mul_y[15:0]};
    assign prod   = {17'b0, mul_x} * {33'b0, mul_yh};
    assign pp_ext = pp_hi_reg ? {1'b0, pp_reg, 16'b0} : {17'b0, pp_reg};

    always_comb begin
        sum_i = acc_reg[DST_PQ] + acc_reg[DST_NQ];
        lt_q  = acc_reg[DST_PQ] < acc_reg[DST_NQ];
        lt_u  = acc_reg[DST_PU] < acc_reg[DST_NU];
        lt_v  = acc_reg[DST_PV] < acc_reg[DST_NV];
        dq = lt_q ? acc_reg[DST_NQ] - acc_reg[DST_PQ] : acc_reg[DST_PQ] - acc_reg[DST_NQ];
        du = lt_u ? acc_reg[DST_NU] - acc_reg[DST_PU] : acc_reg[DST_PU] - acc_reg[DST_NU];
        dv = lt_v ? acc_reg[DST_NV] - acc_reg[DST_PV] : acc_reg[DST_PV] - acc_reg[DST_NV];
    end

    always_comb begin
        ival = quo_reg[0][I_W-1:0];
        ge_i = ival >= avg_i_reg;
        dsm  = ge_i ? ival - avg_i_reg : avg_i_reg - ival;
        rmag = quo_reg[idx_reg + 2'd1];
        rneg = sgn_reg[idx_reg + 2'd1];
        q16  = div_quotient[R_W-1:0];
        y16  = avg_r_reg[idx_reg];
        dd17 = {rat_reg[R_W-1], rat_reg} - {y16[R_W-1], y16};
        dmag = dd17[16] ? (~dd17 + 1'b1) : dd17;
        rstep = rprod_reg[32:16];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:   if (!qstat.empty) state_next = B_MUL;
            B_MUL:    if (step_reg == 4'd15) state_next = B_DRAIN;
            B_DRAIN:  state_next = B_DIFF;
            B_DIFF:   state_next = B_DIV;
            B_DIV:    state_next = B_DIV_W;
            B_DIV_W:  if (div_done) state_next = (idx_reg == 2'd3) ? B_SM_MUL : B_DIV;
            B_SM_MUL: state_next = B_SM_UPD;
            B_SM_UPD: state_next = B_RAT;
            B_RAT: begin
                if (avg_i_reg == '0 || rmag >= {15'b0, avg_i_reg}) state_next = B_RMUL;
                else state_next = B_RAT_W;
            end
            B_RAT_W:  if (div_done) state_next = B_RMUL;
            B_RMUL:   state_next = B_RUPD;
            B_RUPD:   state_next = (idx_reg == 2'd2) ? B_OUT : B_RAT;
            B_OUT:    if (!m_valid_reg || m_ready) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        pop          = 1'b0;
        div_start    = 1'b0;
        div_dividend = dvd_reg[idx_reg];
        div_divisor  = {32'b0, n_reg};
        out_load     = 1'b0;
        unique case (state_reg)
            B_IDLE: pop = !qstat.empty;
            B_DIV:  div_start = 1'b1;
            B_RAT: begin
                div_dividend = {3'b0, rmag[I_W-1:0], 15'b0};
                div_divisor  = avg_i_reg;
                div_start    = !(avg_i_reg == '0 || rmag >= {15'b0, avg_i_reg});
            end
            B_OUT:  out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            pp_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            avg_i_reg   <= '0;
            avg_r_reg[0] <= '0;
            avg_r_reg[1] <= '0;
            avg_r_reg[2] <= '0;
        end else begin
            state_reg  <= state_next;
            pp_vld_reg <= (state_reg == B_MUL);
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == B_SM_UPD) begin
                avg_i_reg <= sm_ge_reg ? avg_i_reg + (smp_hi_reg + {33'b0, smp_lo_reg[31:16]})
                                       : avg_i_reg - (smp_hi_reg + {33'b0, smp_lo_reg[31:16]});
            end
            if (state_reg == B_RUPD) begin
                avg_r_reg[idx_reg] <= rneg_reg ? y16 - rstep[R_W-1:0] : y16 + rstep[R_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pp_vld_reg) begin
            acc_reg[pp_dst_reg] <= acc_reg[pp_dst_reg] + pp_ext;
        end
        unique case (state_reg)
            B_IDLE: begin
                mag_reg[0] <= smag(head_win.shr);
                mag_reg[1] <= smag(head_win.shi);
                mag_reg[2] <= smag(head_win.svr);
                mag_reg[3] <= smag(head_win.svi);
                neg_reg    <= {head_win.svi[SUM_W-1], head_win.svr[SUM_W-1],
                               head_win.shi[SUM_W-1], head_win.shr[SUM_W-1]};
                n_reg      <= head_win.n;
                step_reg   <= '0;
                for (int k = 0; k < 6; k++) acc_reg[k] <= '0;
            end
            B_MUL: begin
                pp_reg     <= prod;
                pp_hi_reg  <= step_reg[0];
                pp_dst_reg <= dst;
                step_reg   <= step_reg + 1'b1;
            end
            B_DIFF: begin
                dvd_reg[0] <= sum_i;
                dvd_reg[1] <= dq;
                dvd_reg[2] <= {du[ACC_W-2:0], 1'b0};
                dvd_reg[3] <= {dv[ACC_W-2:0], 1'b0};
                sgn_reg    <= {lt_v, lt_u, lt_q, 1'b0};
                idx_reg    <= '0;
            end
            B_DIV_W: begin
                if (div_done) begin
                    quo_reg[idx_reg] <= div_quotient[QUO_W-1:0];
                    idx_reg <= (idx_reg == 2'd3) ? 2'd0 : idx_reg + 1'b1;
                end
            end
            B_SM_MUL: begin
                smp_hi_reg <= {16'b0, dsm[I_W-1:16]} * {33'b0, alpha};
                smp_lo_reg <= {16'b0, dsm[15:0]} * {16'b0, alpha};
                sm_ge_reg  <= ge_i;
            end
            B_RAT: begin
                if (avg_i_reg == '0) begin
                    rat_reg <= '0;
                end else if (rmag >= {15'b0, avg_i_reg}) begin
                    rat_reg <= rneg ? 16'h8000 : 16'h7fff;
                end
            end
            B_RAT_W: begin
                if (div_done) rat_reg <= rneg ? (~q16 + 1'b1) : q16;
            end
            B_RMUL: begin
                rneg_reg  <= dd17[16];
                rprod_reg <= {16'b0, dmag} * {17'b0, alpha};
            end
            B_RUPD: begin
                if (idx_reg != 2'd2) idx_reg <= idx_reg + 1'b1;
            end
            B_OUT: begin
                if (out_load) begin
                    o_i_reg  <= quo_reg[0][I_W-1:0];
                    o_q_reg  <= sgn_reg[1] ? ~quo_reg[1][S_W-1:0] + 1'b1 : quo_reg[1][S_W-1:0];
                    o_u_reg  <= sgn_reg[2] ? ~quo_reg[2][S_W-1:0] + 1'b1 : quo_reg[2][S_W-1:0];
                    o_v_reg  <= sgn_reg[3] ? ~quo_reg[3][S_W-1:0] + 1'b1 : quo_reg[3][S_W-1:0];
                    o_si_reg <= avg_i_reg;
                    o_rq_reg <= avg_r_reg[0];
                    o_ru_reg <= avg_r_reg[1];
                    o_rv_reg <= avg_r_reg[2];
                end
            end
            default: ;
        endcase
    end

    assign m_valid            = m_valid_reg;
    assign total_intensity    = o_i_reg;
    assign linear_q           = o_q_reg;
    assign linear_u           = o_u_reg;
    assign circular_v         = o_v_reg;
    assign smoothed_intensity = o_si_reg;
    assign smoothed_q_ratio   = o_rq_reg;
    assign smoothed_u_ratio   = o_ru_reg;
    assign smoothed_v_ratio   = o_rv_reg;

endmodule

/* bench/stokes_window_integrator_top_tb.sv */
module stokes_window_integrator_top_tb;
    import swi_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 600;   // window-end math plus margin
    localparam int HOLD_CYCLES    = 3000;
    localparam int LONG_ITEMS     = 200;
    localparam logic [63:0] MASK49 = (64'd1 << 49) - 1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LEN;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [15:0] s_h_real = '0, s_h_imag = '0, s_v_real = '0, s_v_imag = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [I_W-1:0] m_total_intensity, m_smoothed_intensity;
    logic signed [S_W-1:0] m_linear_q, m_linear_u, m_circular_v;
    logic signed [R_W-1:0] m_smoothed_q_ratio, m_smoothed_u_ratio, m_smoothed_v_ratio;

    always #1 aclk = ~aclk;

    stokes_window_integrator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_h_real(s_h_real), .s_h_imag(s_h_imag), .s_v_real(s_v_real), .s_v_imag(s_v_imag),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_total_intensity(m_total_intensity), .m_linear_q(m_linear_q),
        .m_linear_u(m_linear_u), .m_circular_v(m_circular_v),
        .m_smoothed_intensity(m_smoothed_intensity),
        .m_smoothed_q_ratio(m_smoothed_q_ratio), .m_smoothed_u_ratio(m_smoothed_u_ratio),
        .m_smoothed_v_ratio(m_smoothed_v_ratio)
    );

    // one expected window result
    typedef struct {
        logic [I_W-1:0] intensity;
        logic [S_W-1:0] q, u, v;
        logic [I_W-1:0] sm_intensity;
        logic [R_W-1:0] q_ratio, u_ratio, v_ratio;
    } stokes_result_t;

    stokes_result_t window_results[$];

    // shadow of the block registers and state
    logic [16:0] win_len;
    logic [15:0] alpha;
    logic        swap_hv;
    logic signed [32:0] acc_hr, acc_hi, acc_vr, acc_vi;
    logic [16:0] sample_count;
    logic [63:0] avg_i;
    logic signed [31:0] avg_qr, avg_ur, avg_vr;

    int errors = 0;
    int samples_sent = 0;
    int windows_seen = 0;
    int idle_cycles = 0;
    bit calm = 0;        // no idling on either side while set
    int hold_len = 0;    // receiver hold-off request
    int hold_left = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch in window %0d: %s got %h expected %h", windows_seen, what, got, want);
        errors++;
    endtask

    // one-pole step: floor(d*alpha/2^16)
    function automatic logic [63:0] smooth_step(input logic [63:0] d);
        return (d >> 16) * alpha + (((d & 64'hFFFF) * alpha) >> 16);
    endfunction

    // Q1.15 ratio against the smoothed intensity, saturating
    function automatic logic signed [31:0] pol_ratio(input logic [63:0] mag, input bit neg);
        logic [63:0] r;
        if (avg_i == 0) return 0;
        if (mag >= avg_i) return neg ? -32'sd32768 : 32'sd32767;
        r = (mag << 15) / avg_i;
        return neg ? -$signed(32'(r)) : $signed(32'(r));
    endfunction

    function automatic logic signed [31:0] smooth_ratio(input logic signed [31:0] y,
                                                         input logic signed [31:0] x);
        logic signed [31:0] d;
        logic [31:0] s;
        d = x - y;
        s = (32'(d < 0 ? -d : d) * 32'(alpha)) >> 16;
        return d < 0 ? y - $signed(s) : y + $signed(s);
    endfunction

    // accumulate one sample pair and close the window when due
    task automatic accumulate_sample(input logic signed [15:0] hr, hi, vr, vi);
        logic signed [15:0] t;
        logic [16:0] lim;
        logic signed [127:0] a, b, c, d, n, pow_h, pow_v, cross_re, cross_im;
        logic [127:0] mq, mu, mv;
        logic [63:0] ival, qm, um, vm;
        bit qn, un, vn;
        stokes_result_t r;
        if (win_len == 0) return;
        lim = (win_len > 17'd65536) ? 17'd65536 : win_len;
        if (swap_hv) begin
            t = hr; hr = vr; vr = t;
            t = hi; hi = vi; vi = t;
        end
        acc_hr = acc_hr + hr;
        acc_hi = acc_hi + hi;
        acc_vr = acc_vr + vr;
        acc_vi = acc_vi + vi;
        sample_count = sample_count + 1;
        if (sample_count < lim) return;

        a = acc_hr; b = acc_hi; c = acc_vr; d = acc_vi;
        n = $signed({111'd0, sample_count});
        pow_h = a * a + b * b;
        pow_v = c * c + d * d;
        cross_re = a * c + b * d;
        cross_im = b * c - a * d;
        ival = 64'((pow_h + pow_v) / n) & MASK49;
        qn = (pow_h - pow_v) < 0;
        un = cross_re < 0;
        vn = cross_im < 0;
        mq = qn ? pow_v - pow_h : pow_h - pow_v;
        mu = (un ? -cross_re : cross_re) << 1;
        mv = (vn ? -cross_im : cross_im) << 1;
        qm = 64'(mq / n);
        um = 64'(mu / n);
        vm = 64'(mv / n);

        if (ival >= avg_i) avg_i = avg_i + smooth_step(ival - avg_i);
        else avg_i = avg_i - smooth_step(avg_i - ival);
        avg_qr = smooth_ratio(avg_qr, pol_ratio(qm, qn));
        avg_ur = smooth_ratio(avg_ur, pol_ratio(um, un));
        avg_vr = smooth_ratio(avg_vr, pol_ratio(vm, vn));

        r.intensity = ival[I_W-1:0];
        r.q = qn ? -qm : qm;
        r.u = un ? -um : um;
        r.v = vn ? -vm : vm;
        r.sm_intensity = avg_i[I_W-1:0];
        r.q_ratio = avg_qr[15:0];
        r.u_ratio = avg_ur[15:0];
        r.v_ratio = avg_vr[15:0];
        window_results.insert(window_results.size(), r);

        acc_hr = 0; acc_hi = 0; acc_vr = 0; acc_vi = 0;
        sample_count = 0;
    endtask

    // offer one sample request, hold it until accepted
    task automatic send_sample(input logic [15:0] hr, hi, vr, vi);
        int gap;
        gap = (!calm && $urandom_range(99) < 28) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_h_real <= hr;
        s_h_imag <= hi;
        s_v_real <= vr;
        s_v_imag <= vi;
        do @(posedge aclk); while (!s_ready);
        accumulate_sample(hr, hi, vr, vi);
        samples_sent++;
    endtask

    // mostly random, with a good share of the extremes
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random();
        send_sample(pick_sample(), pick_sample(), pick_sample(), pick_sample());
    endtask

    // stop offering, wait for every expected window, then let the back end settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (window_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_LEN:   win_len = val;
            CFG_ALPHA: alpha = val[15:0];
            CFG_SWAP:  swap_hv = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [16:0] len, input logic [15:0] a, input bit sw);
        write_reg(CFG_LEN, len);
        write_reg(CFG_ALPHA, {1'b0, a});
        write_reg(CFG_SWAP, {16'd0, sw});
    endtask

    // length zero after reset: samples are dropped, state untouched
    task automatic test_disabled();
        repeat (6) send_random();
        drain();
    endtask

    // field extremes, zero intensity, swap, alpha extremes
    task automatic test_directed();
        configure(17'd1, 16'hFFFF, 1'b0);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // zero smoothed intensity
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_sample(16'h8000, 16'h0000, 16'h0000, 16'h0000);  // pure horizontal
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);  // pure vertical
        send_sample(16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001);
        drain();
        configure(17'd2, 16'd0, 1'b1);  // alpha zero freezes the smoothers
        send_sample(16'h1234, 16'h8000, 16'h0000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h0001, 16'hFFFF, 16'h5555);
        send_sample(16'hAAAA, 16'h5555, 16'h8000, 16'h0000);
        send_sample(16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF);
        drain();
        // window of five left open at two samples, then shortened to two
        configure(17'd5, 16'h8000, 1'b0);
        send_sample(16'h4000, 16'hC000, 16'h2000, 16'h0100);
        send_sample(16'h3000, 16'hD000, 16'h1000, 16'h0200);
        drain();
        write_reg(CFG_LEN, 17'd2);
        send_sample(16'h2000, 16'hE000, 16'h0800, 16'h0300);  // closes with three samples
        drain();
    endtask

    // oversized length keeps a long window open, then a short length closes it
    task automatic test_max_window();
        configure(17'h1FFFF, 16'h8000, 1'b0);
        calm = 1;
        repeat (LONG_ITEMS) send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        calm = 0;
        drain();
        write_reg(CFG_LEN, 17'd2);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        drain();
    endtask

    // receiver holds off so the window queue fills and intake stalls
    task automatic test_backpressure();
        configure(17'd1, 16'h4000, 1'b0);
        hold_len = HOLD_CYCLES;
        repeat (30) send_random();
        drain();
    endtask

    // random settings, mostly short windows
    task automatic test_random();
        logic [16:0] len;
        logic [15:0] a;
        int phase_items;
        for (int phase = 0; phase < 20; phase++) begin
            case ($urandom_range(5))
                0: len = 17'd1;
                1: len = 17'($urandom_range(64, 9));
                default: len = 17'($urandom_range(8, 1));
            endcase
            case ($urandom_range(3))
                0: a = 16'hFFFF;
                1: a = 16'd0;
                default: a = 16'($urandom);
            endcase
            configure(len, a, $urandom_range(1));
            calm = (phase == 5);
            phase_items = $urandom_range(70, 30);
            repeat (phase_items) send_random();
            calm = 0;
            drain();
        end
        // disable again mid stream: partial sums must survive
        write_reg(CFG_LEN, 17'd0);
        repeat (5) send_random();
        drain();
        write_reg(CFG_LEN, 17'd3);
        repeat (30) send_random();
        drain();
    endtask

    // receiver: random stalls, or a long counted hold-off on request
    always @(posedge aclk) begin
        if (hold_len != 0) begin
            hold_left <= hold_len;
            hold_len = 0;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 28);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        stokes_result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (window_results.size() == 0) begin
                report("unexpected result, total_intensity", m_total_intensity, 64'd0);
            end else begin
                w = window_results.pop_front();
                if (m_total_intensity !== w.intensity)
                    report("total_intensity", m_total_intensity, w.intensity);
                if (m_linear_q !== w.q) report("linear_q", m_linear_q, w.q);
                if (m_linear_u !== w.u) report("linear_u", m_linear_u, w.u);
                if (m_circular_v !== w.v) report("circular_v", m_circular_v, w.v);
                if (m_smoothed_intensity !== w.sm_intensity)
                    report("smoothed_intensity", m_smoothed_intensity, w.sm_intensity);
                if (m_smoothed_q_ratio !== w.q_ratio)
                    report("smoothed_q_ratio", m_smoothed_q_ratio, w.q_ratio);
                if (m_smoothed_u_ratio !== w.u_ratio)
                    report("smoothed_u_ratio", m_smoothed_u_ratio, w.u_ratio);
                if (m_smoothed_v_ratio !== w.v_ratio)
                    report("smoothed_v_ratio", m_smoothed_v_ratio, w.v_ratio);
            end
            windows_seen++;
        end
    end

    // watchdog: too long with no request moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        win_len = 0; alpha = 0; swap_hv = 0;
        acc_hr = 0; acc_hi = 0; acc_vr = 0; acc_vi = 0;
        sample_count = 0; avg_i = 0;
        avg_qr = 0; avg_ur = 0; avg_vr = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_disabled();
        test_directed();
        test_max_window();
        test_backpressure();
        test_random();

        if (window_results.size() != 0) begin
            report("results never arrived, count", 64'(window_results.size()), 64'd0);
        end
        $display("sent %0d sample requests, checked %0d windows", samples_sent, windows_seen);
        $display("covered disabled intake, swap, alpha extremes, oversized and shortened windows");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
